### design/login_attempt_rate_limiter_macros.svh
// Assertion macros shared by the login attempt rate limiter.
// Depends on nothing; each macro expects i_clk and i_rst_n in scope.
`ifndef LOGIN_ATTEMPT_RATE_LIMITER_MACROS_SVH
`define LOGIN_ATTEMPT_RATE_LIMITER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LARL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LARL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/larl_pkg.sv
// Package for the login attempt rate limiter: sizes, request and response types,
// register indexes, sequencer states and the remaining-attempts helper. No dependencies.
package larl_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int MAX_TRIES     = 8;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W        = (MAX_TRIES > 1) ? $clog2(MAX_TRIES) : 1;
    localparam int CNT_W         = $clog2(MAX_TRIES + 1);
    localparam int MEM_DEPTH     = TABLE_ENTRIES * (1 << SLOT_W);
    localparam int MEM_AW        = IDX_W + SLOT_W;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_DURATION = 2'd2;

    localparam logic OP_LOGIN = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] client_addr;
        logic [31:0] now_time;
        logic        credential_ok;
    } t_req;

    typedef struct packed {
        logic       granted;
        logic       refused_blocked;
        logic [3:0] attempts_left;
        logic       table_full;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRUNE_ENT,
        ST_RD,
        ST_CHK,
        ST_SEARCH,
        ST_DECIDE
    } t_state;

    // Limit minus stored attempts, floored at zero.
    function automatic logic [3:0] left_for(input logic [3:0] lim, input logic [4:0] cnt);
        logic [4:0] lim_x;
        lim_x = {1'b0, lim};
        left_for = (lim_x > cnt) ? 4'(lim_x - cnt) : 4'd0;
    endfunction

endpackage

### design/login_attempt_rate_limiter.sv
// Login attempt rate limiter: per-client sliding window with a blocklist.
// A query searches every table entry before the decision. A login first prunes every valid
// entry, clearing an expired block and reading and checking each stored timestamp,
// then searches the table and decides.
// One request at a time; the next is taken while the previous response waits.
// Synchronous active-low reset clears the table flags and loads the register defaults.
`include "login_attempt_rate_limiter_macros.svh"

module login_attempt_rate_limiter
    import larl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_req                  i_req,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_rsp                  o_rsp
);

    // Configuration registers.
    logic [3:0]  r_max_att;
    logic [30:0] r_window;
    logic [30:0] r_block_dur;

    // Entry table.
    logic                r_valid  [TABLE_ENTRIES];
    logic [31:0]         r_client [TABLE_ENTRIES];
    logic [CNT_W-1:0]    r_cnt    [TABLE_ENTRIES];
    logic                r_block  [TABLE_ENTRIES];
    logic [31:0]         r_bstart [TABLE_ENTRIES];

    // Attempt timestamp memory, one row of slots per entry.
    logic [31:0] r_mem [MEM_DEPTH];
    logic [31:0] r_rdata;

    // Sequencer state.
    t_state           r_state, n_state;
    t_req             r_req;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_k;
    logic [CNT_W-1:0] r_kept;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;
    logic             r_out_valid;
    t_rsp             r_out;

    logic [3:0]        lim;
    logic [31:0]       sub_b;
    logic [31:0]       age;
    logic [31:0]       thr;
    logic              expired;
    logic              last;
    logic              rd_more;
    logic [IDX_W-1:0]  e_sel;
    logic [CNT_W-1:0]  cnt_eff;
    logic [3:0]        left_eff;
    logic [3:0]        left_nxt;
    logic              d_blocked;
    logic              d_full;
    logic              d_block_now;
    logic              d_record;
    logic              commit;
    logic              mem_re;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_raddr;
    logic [MEM_AW-1:0] mem_waddr;
    logic [31:0]       mem_wdata;
    t_rsp              rsp;

    // Effective limit and the shared age subtract and compare unit.
    assign lim     = (r_max_att > 4'(MAX_TRIES)) ? 4'(MAX_TRIES) : r_max_att;
    assign sub_b   = (r_state == ST_PRUNE_ENT) ? r_bstart[r_idx] : r_rdata;
    assign thr     = (r_state == ST_PRUNE_ENT) ? {1'b0, r_block_dur} : {1'b0, r_window};
    assign age     = r_req.now_time - sub_b;
    assign expired = age > thr;
    assign last    = r_idx == IDX_W'(TABLE_ENTRIES - 1);
    assign rd_more = r_k < r_cnt[r_idx];

    // Decision terms for the matched or newly allocated entry.
    assign e_sel       = r_hit ? r_hit_idx : r_free_idx;
    assign cnt_eff     = r_hit ? r_cnt[r_hit_idx] : '0;
    assign left_eff    = left_for(lim, 5'(cnt_eff));
    assign left_nxt    = left_for(lim, 5'(cnt_eff) + 5'd1);
    assign d_blocked   = r_hit && r_block[r_hit_idx];
    assign d_full      = !r_hit && !r_free;
    assign d_block_now = !d_blocked && !d_full && (left_eff == 4'd0);
    assign d_record    = !d_blocked && !d_full && (left_eff != 4'd0);
    assign commit      = (r_state == ST_DECIDE) && (!r_out_valid || i_out_ready);

    // Response for the current request.
    always_comb begin
        rsp = '0;
        if (r_req.op == OP_QUERY) begin
            rsp.attempts_left = r_hit ? left_eff : lim;
        end else if (d_blocked) begin
            rsp.refused_blocked = 1'b1;
            rsp.attempts_left   = left_eff;
        end else if (d_full) begin
            rsp.table_full    = 1'b1;
            rsp.attempts_left = lim;
        end else if (d_block_now) begin
            rsp.refused_blocked = 1'b1;
        end else if (r_req.credential_ok) begin
            rsp.granted       = 1'b1;
            rsp.attempts_left = lim;
        end else begin
            rsp.attempts_left = left_nxt;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_req.op == OP_QUERY) ? ST_SEARCH : ST_PRUNE_ENT;
                end
            end
            ST_PRUNE_ENT: begin
                if (r_valid[r_idx]) begin
                    n_state = ST_RD;
                end else if (last) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_RD: begin
                if (rd_more) begin
                    n_state = ST_CHK;
                end else begin
                    n_state = last ? ST_SEARCH : ST_PRUNE_ENT;
                end
            end
            ST_CHK: n_state = ST_RD;
            ST_SEARCH: begin
                if (last) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and memory port controls.
    always_comb begin
        o_in_ready = 1'b0;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        mem_raddr  = {r_idx, r_k[SLOT_W-1:0]};
        mem_waddr  = {r_idx, r_kept[SLOT_W-1:0]};
        mem_wdata  = r_rdata;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_RD:   mem_re = rd_more;
            ST_CHK:  mem_we = !expired;
            ST_DECIDE: begin
                mem_we    = commit && (r_req.op == OP_LOGIN) && d_record;
                mem_waddr = {e_sel, cnt_eff[SLOT_W-1:0]};
                mem_wdata = r_req.now_time;
            end
            default: ;
        endcase
    end

    // Attempt memory: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_att   <= 4'd3;
            r_window    <= 31'd300000;
            r_block_dur <= 31'd900000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_ATTEMPTS:   r_max_att   <= i_cfg_data[3:0];
                CFG_ATTEMPT_WINDOW: r_window    <= i_cfg_data;
                CFG_BLOCK_DURATION: r_block_dur <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Table payload without reset: client keys, block stamps, the held request and the response.
    always_ff @(posedge i_clk) begin
        if (commit && (r_req.op == OP_LOGIN)) begin
            if (!r_hit && r_free) begin
                r_client[e_sel] <= r_req.client_addr;
            end
            if (d_block_now) begin
                r_bstart[e_sel] <= r_req.now_time;
            end
        end
        if (r_state == ST_IDLE && i_in_valid) begin
            r_req <= i_req;
        end
        if (commit) begin
            r_out <= rsp;
        end
    end

    // Sequencer counters, table flags and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_k         <= '0;
            r_kept      <= '0;
            r_hit       <= 1'b0;
            r_hit_idx   <= '0;
            r_free      <= 1'b0;
            r_free_idx  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_cnt[i]   <= '0;
                r_block[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_idx  <= '0;
                    r_hit  <= 1'b0;
                    r_free <= 1'b0;
                end
                ST_PRUNE_ENT: begin
                    r_k    <= '0;
                    r_kept <= '0;
                    if (r_valid[r_idx]) begin
                        if (r_block[r_idx] && expired) begin
                            r_block[r_idx] <= 1'b0;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_RD: begin
                    if (!rd_more) begin
                        r_cnt[r_idx] <= r_kept;
                        if (r_kept == '0 && !r_block[r_idx]) begin
                            r_valid[r_idx] <= 1'b0;
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_CHK: begin
                    r_k <= r_k + 1'b1;
                    if (!expired) begin
                        r_kept <= r_kept + 1'b1;
                    end
                end
                ST_SEARCH: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_valid[r_idx] && r_client[r_idx] == r_req.client_addr && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_idx;
                    end
                    if (!r_valid[r_idx] && !r_free) begin
                        r_free     <= 1'b1;
                        r_free_idx <= r_idx;
                    end
                end
                ST_DECIDE: begin
                    // A new client takes the free entry; a block keeps the stored attempts.
                    if (commit && (r_req.op == OP_LOGIN) && !d_blocked && !d_full) begin
                        if (d_block_now) begin
                            r_valid[e_sel] <= 1'b1;
                            r_cnt[e_sel]   <= cnt_eff;
                            r_block[e_sel] <= 1'b1;
                        end else if (r_req.credential_ok) begin
                            r_valid[e_sel] <= 1'b0;
                            r_cnt[e_sel]   <= '0;
                            r_block[e_sel] <= 1'b0;
                        end else begin
                            r_valid[e_sel] <= 1'b1;
                            r_cnt[e_sel]   <= cnt_eff + 1'b1;
                            r_block[e_sel] <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_out;

    // Checks on the sequencer and the decision logic.
    `LARL_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt[r_idx] <= CNT_W'(MAX_TRIES), "count too large")
    `LARL_ASSERT_NEXT(a_busy_after_take, i_in_valid && o_in_ready, r_state != ST_IDLE, "idle")
    `LARL_ASSERT_NOW(a_out_from_decide, $rose(r_out_valid), $past(r_state) == ST_DECIDE, "early")
    `LARL_ASSERT_NOW(a_grant_excl, r_out_valid && r_out.granted, !r_out.refused_blocked && !r_out.table_full, "grant with refusal")
    `LARL_ASSERT_NOW(a_compact_order, r_state == ST_CHK, r_kept <= r_k, "write ahead of read")

endmodule

### tb/login_attempt_rate_limiter_tb.sv
// Self-checking testbench for the login attempt rate limiter.
// Depends on larl_pkg and login_attempt_rate_limiter; drives requests, predicts responses.
module login_attempt_rate_limiter_tb;
    import larl_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_req                  i_req;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_rsp                  o_rsp;

    login_attempt_rate_limiter uut (.*);

    localparam int LIMIT_CYCLES = 3000000;
    localparam int DRAIN_CYCLES = 400;

    // Predictor copy of the limiter state and registers.
    logic [3:0]  lim_cfg;
    logic [30:0] win_cfg;
    logic [30:0] blk_cfg;
    logic        ent_used [TABLE_ENTRIES];
    logic [31:0] ent_addr [TABLE_ENTRIES];
    logic [31:0] ent_stamp [TABLE_ENTRIES][MAX_TRIES];
    int          ent_cnt [TABLE_ENTRIES];
    logic        ent_blk [TABLE_ENTRIES];
    logic [31:0] ent_blk_t [TABLE_ENTRIES];

    t_rsp        rsp_queue [$];
    int          fail_cnt;
    int          cycle_cnt;
    int          sent_cnt;

    // Directed rows: request plus an optional typed-in response.
    typedef struct {
        t_req req;
        bit   has_rsp;
        t_rsp rsp;
    } t_row;
    t_row rows [$];

    // Random address pool and clock for the random phase.
    logic [31:0] addr_pool [8];
    logic [31:0] tick;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        cycle_cnt = 0;
        wait (cycle_cnt >= LIMIT_CYCLES);
        $display("Some tests failed");
        $finish;
    end

    function automatic int lim_eff();
        return (lim_cfg < MAX_TRIES) ? int'(lim_cfg) : MAX_TRIES;
    endfunction

    function automatic logic [3:0] left_count(int cnt);
        return (lim_eff() > cnt) ? 4'(lim_eff() - cnt) : 4'd0;
    endfunction

    function automatic int find_entry(logic [31:0] addr);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (ent_used[i] && ent_addr[i] == addr) return i;
        return -1;
    endfunction

    task automatic clear_model();
        lim_cfg = 4'd3;
        win_cfg = 31'd300000;
        blk_cfg = 31'd900000;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            ent_used[i] = 1'b0;
            ent_cnt[i]  = 0;
            ent_blk[i]  = 1'b0;
        end
    endtask

    // Expected response for one login or query request; updates the copy of the table.
    function automatic t_rsp predict_login(t_req r);
        t_rsp o;
        int   e;
        int   kept;
        o = '0;
        if (r.op == OP_QUERY) begin
            e = find_entry(r.client_addr);
            o.attempts_left = (e < 0) ? 4'(lim_eff()) : left_count(ent_cnt[e]);
            return o;
        end
        // Drop expired blocks and attempts in every entry.
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!ent_used[i]) continue;
            if (ent_blk[i] && (r.now_time - ent_blk_t[i]) > {1'b0, blk_cfg})
                ent_blk[i] = 1'b0;
            kept = 0;
            for (int k = 0; k < ent_cnt[i]; k++)
                if ((r.now_time - ent_stamp[i][k]) <= {1'b0, win_cfg}) begin
                    ent_stamp[i][kept] = ent_stamp[i][k];
                    kept++;
                end
            ent_cnt[i] = kept;
            if (kept == 0 && !ent_blk[i]) ent_used[i] = 1'b0;
        end
        e = find_entry(r.client_addr);
        if (e >= 0 && ent_blk[e]) begin
            o.refused_blocked = 1'b1;
            o.attempts_left   = left_count(ent_cnt[e]);
            return o;
        end
        if (e < 0) begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (!ent_used[i]) begin
                    e = i;
                    break;
                end
            if (e >= 0) begin
                ent_used[e] = 1'b1;
                ent_addr[e] = r.client_addr;
                ent_cnt[e]  = 0;
                ent_blk[e]  = 1'b0;
            end
        end
        if (e < 0) begin
            o.table_full    = 1'b1;
            o.attempts_left = 4'(lim_eff());
        end else if (left_count(ent_cnt[e]) == 0) begin
            ent_blk[e]        = 1'b1;
            ent_blk_t[e]      = r.now_time;
            o.refused_blocked = 1'b1;
        end else begin
            ent_stamp[e][ent_cnt[e]] = r.now_time;
            ent_cnt[e]++;
            if (r.credential_ok) begin
                o.granted       = 1'b1;
                ent_cnt[e]      = 0;
                ent_used[e]     = 1'b0;
                o.attempts_left = 4'(lim_eff());
            end else begin
                o.attempts_left = left_count(ent_cnt[e]);
            end
        end
        return o;
    endfunction

    // Mostly short gaps, now and then a long one, sometimes none.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Appends an expected response at the tail of the queue.
    task automatic queue_rsp(t_rsp want);
        rsp_queue.insert(rsp_queue.size(), want);
    endtask

    // Drives one request after a random gap; valid stays high until the next
    // request or until the sequence drains, so it is never assigned twice in a step.
    task automatic drive_req(t_req r, t_rsp want);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        queue_rsp(want);
        i_req      <= r;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sent_cnt++;
    endtask

    task automatic send_req(t_req r);
        drive_req(r, predict_login(r));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (rsp_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the enable is dropped by the caller after the last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_MAX_ATTEMPTS) lim_cfg = val[3:0];
        else if (idx == CFG_ATTEMPT_WINDOW) win_cfg = val;
        else if (idx == CFG_BLOCK_DURATION) blk_cfg = val;
    endtask

    function automatic t_req mk(logic op, logic [31:0] a, logic [31:0] t, logic c);
        t_req r;
        r.op = op;
        r.client_addr = a;
        r.now_time = t;
        r.credential_ok = c;
        return r;
    endfunction

    task automatic add_row(t_req r, bit has, t_rsp o);
        t_row w;
        w.req = r;
        w.has_rsp = has;
        w.rsp = o;
        rows.insert(rows.size(), w);
    endtask

    // Response checker and random back-pressure on the output.
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (rsp_queue.size() == 0) begin
                    $display("%0t: unexpected response %p", $time, o_rsp);
                    fail_cnt++;
                end else begin
                    want = rsp_queue.pop_front();
                    if (want.granted !== o_rsp.granted ||
                        want.refused_blocked !== o_rsp.refused_blocked ||
                        want.attempts_left !== o_rsp.attempts_left ||
                        want.table_full !== o_rsp.table_full) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, o_rsp);
                        fail_cnt++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(0, 99) < 70) || (cycle_cnt[9:8] == 2'b11);
        end
    end

    initial begin
        t_req r;
        t_rsp o;
        t_rsp exp_row;
        int   phase_items;
        fail_cnt    = 0;
        sent_cnt    = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_MAX_ATTEMPTS;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_req       = '0;
        clear_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: query on empty table, limit walk, block, expiry, extremes.
        o = '0;
        o.attempts_left = 4'd3;
        add_row(mk(OP_QUERY, 32'hFFFF_FFFF, 32'd0, 1'b1), 1, o);
        o.attempts_left = 4'd2;
        add_row(mk(OP_LOGIN, 32'h0000_0000, 32'd0, 1'b0), 1, o);
        o.attempts_left = 4'd1;
        add_row(mk(OP_LOGIN, 32'h0000_0000, 32'd5, 1'b0), 1, o);
        o.attempts_left = 4'd0;
        add_row(mk(OP_LOGIN, 32'h0000_0000, 32'd6, 1'b0), 1, o);
        o = '0;
        o.refused_blocked = 1'b1;
        add_row(mk(OP_LOGIN, 32'h0000_0000, 32'd7, 1'b1), 1, o);
        add_row(mk(OP_QUERY, 32'h0000_0000, 32'd8, 1'b0), 0, o);
        add_row(mk(OP_LOGIN, 32'h0000_0000, 32'd900007, 1'b1), 0, o);
        add_row(mk(OP_LOGIN, 32'h0000_0000, 32'd900008, 1'b1), 0, o);
        o = '0;
        o.granted = 1'b1;
        o.attempts_left = 4'd3;
        add_row(mk(OP_LOGIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 1, o);
        add_row(mk(OP_LOGIN, 32'hA5A5_5A5A, 32'hFFFF_FFF0, 1'b0), 0, o);
        add_row(mk(OP_LOGIN, 32'hA5A5_5A5A, 32'h0000_0010, 1'b0), 0, o);
        add_row(mk(OP_LOGIN, 32'hA5A5_5A5A, 32'h8000_0000, 1'b0), 0, o);
        foreach (rows[i]) begin
            exp_row = predict_login(rows[i].req);
            if (rows[i].has_rsp && exp_row != rows[i].rsp) begin
                $display("%0t: table row %0d expected %p actual %p",
                         $time, i, rows[i].rsp, exp_row);
                fail_cnt++;
            end
            drive_req(rows[i].req, exp_row);
        end
        rows.delete();

        // Full table: sixteen clients, each one failed attempt, then a seventeenth.
        for (int i = 0; i < TABLE_ENTRIES; i++)
            send_req(mk(OP_LOGIN, 32'h1000_0000 + i, 32'h9000_0000, 1'b0));
        o = '0;
        o.table_full = 1'b1;
        o.attempts_left = 4'd3;
        r = mk(OP_LOGIN, 32'h2000_0000, 32'h9000_0001, 1'b1);
        exp_row = predict_login(r);
        if (exp_row != o) begin
            $display("%0t: full table expected %p actual %p", $time, o, exp_row);
            fail_cnt++;
        end
        drive_req(r, exp_row);
        wait_idle();

        // Random phases under several register settings, extremes included.
        tick = $urandom;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_MAX_ATTEMPTS, 31'd1);
                    write_reg(CFG_ATTEMPT_WINDOW, 31'd1);
                    write_reg(CFG_BLOCK_DURATION, 31'd1);
                end
                1: begin
                    write_reg(CFG_MAX_ATTEMPTS, 31'd8);
                    write_reg(CFG_ATTEMPT_WINDOW, 31'h7FFF_FFFF);
                    write_reg(CFG_BLOCK_DURATION, 31'h7FFF_FFFF);
                end
                2: write_reg(CFG_MAX_ATTEMPTS, 31'd15);
                3: write_reg(CFG_MAX_ATTEMPTS, 31'd0);
                4: write_reg(CFG_MAX_ATTEMPTS, 31'd2);
                default: begin
                    write_reg(CFG_MAX_ATTEMPTS, 31'($urandom_range(1, 8)));
                    write_reg(CFG_ATTEMPT_WINDOW, 31'($urandom_range(1, 400)));
                    write_reg(CFG_BLOCK_DURATION, 31'($urandom_range(1, 800)));
                end
            endcase
            i_cfg_we <= 1'b0;
            for (int i = 0; i < 8; i++)
                addr_pool[i] = (i < 2) ? {32{i[0]}} : $urandom;
            phase_items = 150;
            for (int n = 0; n < phase_items; n++) begin
                if ($urandom_range(0, 9) == 0) tick = $urandom;
                else tick = tick + $urandom_range(0, (ph < 2) ? 3 : 120);
                r.op = ($urandom_range(0, 4) == 0) ? OP_QUERY : OP_LOGIN;
                r.client_addr = ($urandom_range(0, 9) == 0) ? $urandom
                                : addr_pool[$urandom_range(0, 7)];
                r.now_time = tick;
                r.credential_ok = ($urandom_range(0, 4) == 0);
                send_req(r);
            end
            wait_idle();
        end

        wait_idle();
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
